@@ src/sha_pkg.sv @@
// SHA-256 hasher package: types, constants, round constants and round helpers.
// No dependencies.
`timescale 1ns / 1ps
package sha_pkg;

  localparam int unsigned HashWords = 8;
  localparam int unsigned BlockBytes = 64;
  localparam int unsigned Rounds = 64;

  localparam logic [31:0] IV [HashWords] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [7:0] PadByte = 8'h80;
  localparam logic [63:0] BlockBits = 64'd512;

  localparam logic KindData = 1'b0;
  localparam logic KindFinish = 1'b1;

  // Byte source selected by the controller for a buffer write.
  typedef enum logic [1:0] {
    SRC_DATA = 2'd0,
    SRC_PAD  = 2'd1,
    SRC_ZERO = 2'd2,
    SRC_LEN  = 2'd3
  } byte_src_e;

  typedef struct packed {
    logic       buf_we;     // write one byte at fill position
    byte_src_e  buf_src;
    logic       fill_clr;   // fill back to zero
    logic       cmp_start;  // load working vars, start 64 rounds
    logic       len_add;    // bit_length += 512
    logic       snap_len;   // capture total length for padding
    logic       hash_init;  // return to initial state
  } ctrl_cmd_t;

  typedef struct packed {
    logic [5:0] fill;
    logic       cmp_busy;
  } ctrl_sts_t;

  function automatic logic [31:0] round_k(input logic [5:0] idx);
    logic [31:0] k [64];
    k = '{
      32'h428a2f98,32'h71374491,32'hb5c0fbcf,32'he9b5dba5,32'h3956c25b,32'h59f111f1,
      32'h923f82a4,32'hab1c5ed5,32'hd807aa98,32'h12835b01,32'h243185be,32'h550c7dc3,
      32'h72be5d74,32'h80deb1fe,32'h9bdc06a7,32'hc19bf174,32'he49b69c1,32'hefbe4786,
      32'h0fc19dc6,32'h240ca1cc,32'h2de92c6f,32'h4a7484aa,32'h5cb0a9dc,32'h76f988da,
      32'h983e5152,32'ha831c66d,32'hb00327c8,32'hbf597fc7,32'hc6e00bf3,32'hd5a79147,
      32'h06ca6351,32'h14292967,32'h27b70a85,32'h2e1b2138,32'h4d2c6dfc,32'h53380d13,
      32'h650a7354,32'h766a0abb,32'h81c2c92e,32'h92722c85,32'ha2bfe8a1,32'ha81a664b,
      32'hc24b8b70,32'hc76c51a3,32'hd192e819,32'hd6990624,32'hf40e3585,32'h106aa070,
      32'h19a4c116,32'h1e376c08,32'h2748774c,32'h34b0bcb5,32'h391c0cb3,32'h4ed8aa4a,
      32'h5b9cca4f,32'h682e6ff3,32'h748f82ee,32'h78a5636f,32'h84c87814,32'h8cc70208,
      32'h90befffa,32'ha4506ceb,32'hbef9a3f7,32'hc67178f2
    };
    return k[idx];
  endfunction

  function automatic logic [31:0] ror(input logic [31:0] x, input int unsigned n);
    return (x >> n) | (x << (32 - n));
  endfunction

endpackage

@@ src/sha_if.sv @@
// Valid/ready stream interfaces for the hasher input and digest output.
// Depends on nothing.
`timescale 1ns / 1ps
interface sha_in_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] data_byte;
  modport source (output valid, kind, data_byte, input ready);
  modport sink (input valid, kind, data_byte, output ready);
endinterface

interface sha_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        last_word;
  modport source (output valid, digest_word, word_index, last_word, input ready);
  modport sink (input valid, digest_word, word_index, last_word, output ready);
endinterface

@@ src/sha256_byte_stream_hasher_top.sv @@
// Top level of the SHA-256 byte-stream hasher.
// Depends on sha_pkg, sha_if, sha_ctrl and sha_datapath.
`timescale 1ns / 1ps
// SHA-256 over a byte stream. A data beat (kind 0) appends one byte; the
// 64th byte of a block starts compression in the single round unit, during
// which input is held off. A finish beat (kind 1) pads the buffer one byte
// per cycle, pausing for an extra compression when 56 or more bytes are
// pending, compresses, then offers the eight digest words, word 0 first,
// last_word marking word 7. After the last word is taken the block returns
// to the initial hash values and accepts input again.
module sha256_byte_stream_hasher_top (
  input  logic clk_i,
  input  logic rst_ni,
  sha_in_if.sink    in_if,
  sha_out_if.source out_if
);
  import sha_pkg::*;

  ctrl_cmd_t   cmd;
  ctrl_sts_t   sts;
  logic [2:0]  rd_idx;
  logic [31:0] hash_word;

  sha_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_if, .out_if,
    .cmd_o(cmd), .sts_i(sts), .rd_idx_o(rd_idx), .hash_word_i(hash_word)
  );

  sha_datapath u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .sts_o(sts),
    .data_byte_i(in_if.data_byte), .rd_idx_i(rd_idx), .hash_word_o(hash_word)
  );
endmodule

@@ src/sha_datapath.sv @@
// Datapath: block buffer, length counter, message schedule and round unit.
// Depends on sha_pkg.
`timescale 1ns / 1ps
module sha_datapath (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  sha_pkg::ctrl_cmd_t cmd_i,
  output sha_pkg::ctrl_sts_t sts_o,
  input  logic [7:0]         data_byte_i,
  input  logic [2:0]         rd_idx_i,
  output logic [31:0]        hash_word_o
);
  import sha_pkg::*;

  logic [5:0]  fill_q, fill_d;
  logic [63:0] len_q, total_q;
  logic [31:0] h_q [HashWords];
  logic [31:0] v_q [HashWords];
  logic [31:0] w_q [16];
  logic [5:0]  rnd_q;
  logic        busy_q;
  logic [7:0]  wr_byte;
  logic [2:0]  len_sel;

  // Length bytes fill positions 56..63, most significant first.
  assign len_sel = 3'd7 - fill_q[2:0];

  always_comb begin
    case (cmd_i.buf_src)
      SRC_DATA: wr_byte = data_byte_i;
      SRC_PAD:  wr_byte = PadByte;
      SRC_ZERO: wr_byte = 8'h00;
      default:  wr_byte = total_q[{len_sel, 3'b000} +: 8];
    endcase
  end

  assign fill_d = cmd_i.fill_clr ? 6'd0 : (cmd_i.buf_we ? fill_q + 6'd1 : fill_q);

  // Schedule: w_q[0] is the word for the current round; a 16-deep shift line.
  // Between blocks the same registers hold the pending bytes, big-endian
  // within each word; every byte of a block is written before it compresses.
  logic [31:0] w_next, s0, s1, t1, t2, ch, mj, e, a;
  assign s0 = ror(w_q[1], 7) ^ ror(w_q[1], 18) ^ (w_q[1] >> 3);
  assign s1 = ror(w_q[14], 17) ^ ror(w_q[14], 19) ^ (w_q[14] >> 10);
  assign w_next = s1 + w_q[9] + s0 + w_q[0];
  assign e = v_q[4];
  assign a = v_q[0];
  assign ch = (e & v_q[5]) ^ (~e & v_q[6]);
  assign mj = (a & v_q[1]) ^ (a & v_q[2]) ^ (v_q[1] & v_q[2]);
  assign t1 = v_q[7] + (ror(e, 6) ^ ror(e, 11) ^ ror(e, 25)) + ch + round_k(rnd_q) + w_q[0];
  assign t2 = (ror(a, 2) ^ ror(a, 13) ^ ror(a, 22)) + mj;

  always_ff @(posedge clk_i) begin
    if (cmd_i.cmp_start) begin
      for (int i = 0; i < HashWords; i++) begin
        v_q[i] <= h_q[i];
      end
    end else if (busy_q) begin
      for (int i = 0; i < 15; i++) begin
        w_q[i] <= w_q[i+1];
      end
      w_q[15] <= w_next;
      v_q[7] <= v_q[6]; v_q[6] <= v_q[5]; v_q[5] <= v_q[4]; v_q[4] <= v_q[3] + t1;
      v_q[3] <= v_q[2]; v_q[2] <= v_q[1]; v_q[1] <= v_q[0]; v_q[0] <= t1 + t2;
    end else if (cmd_i.buf_we) begin
      w_q[fill_q[5:2]][{~fill_q[1:0], 3'b000} +: 8] <= wr_byte;
    end
    if (cmd_i.snap_len) begin
      total_q <= len_q + {55'd0, fill_q, 3'd0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
      len_q  <= '0;
      busy_q <= 1'b0;
      rnd_q  <= '0;
      for (int i = 0; i < HashWords; i++) h_q[i] <= IV[i];
    end else begin
      fill_q <= fill_d;
      if (cmd_i.hash_init) begin
        len_q <= '0;
        for (int i = 0; i < HashWords; i++) h_q[i] <= IV[i];
      end else begin
        if (cmd_i.len_add) len_q <= len_q + BlockBits;
        if (busy_q && rnd_q == 6'd63) begin
          h_q[0] <= h_q[0] + t1 + t2;
          h_q[1] <= h_q[1] + v_q[0];
          h_q[2] <= h_q[2] + v_q[1];
          h_q[3] <= h_q[3] + v_q[2];
          h_q[4] <= h_q[4] + v_q[3] + t1;
          h_q[5] <= h_q[5] + v_q[4];
          h_q[6] <= h_q[6] + v_q[5];
          h_q[7] <= h_q[7] + v_q[6];
        end
      end
      if (cmd_i.cmp_start) begin
        busy_q <= 1'b1;
        rnd_q  <= '0;
      end else if (busy_q) begin
        rnd_q <= rnd_q + 6'd1;
        if (rnd_q == 6'd63) busy_q <= 1'b0;
      end
    end
  end

  assign sts_o.fill = fill_q;
  assign sts_o.cmp_busy = busy_q;
  assign hash_word_o = h_q[rd_idx_i];

  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.cmp_start |-> !busy_q) else $error("compression started while busy");
  a_no_write_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> !cmd_i.buf_we) else $error("buffer written during rounds");
  a_round_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q && rnd_q == 6'd63) |=> !busy_q) else $error("round count overrun");
endmodule

@@ src/sha_ctrl.sv @@
// Controller: input handshake, padding sequence, compression launch, digest out.
// Depends on sha_pkg and the stream interfaces.
`timescale 1ns / 1ps
module sha_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  sha_in_if.sink             in_if,
  sha_out_if.source          out_if,
  output sha_pkg::ctrl_cmd_t cmd_o,
  input  sha_pkg::ctrl_sts_t sts_i,
  output logic [2:0]         rd_idx_o,
  input  logic [31:0]        hash_word_i
);
  import sha_pkg::*;

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StWait = 3'd1; // compression of a data block
  localparam logic [2:0] StPad  = 3'd2; // writing zeros / length
  localparam logic [2:0] StPadW = 3'd3; // first padding block compressing
  localparam logic [2:0] StFinW = 3'd4; // final block compressing
  localparam logic [2:0] StOut  = 3'd5;

  logic [2:0] st_q, st_d;
  logic [2:0] idx_q, idx_d;
  logic       extra_q, extra_d; // a second padding block is needed
  logic       in_fire, out_fire;
  logic       launched_q, launched_d;

  assign in_fire  = in_if.valid && in_if.ready;
  assign out_fire = out_if.valid && out_if.ready;
  assign in_if.ready = (st_q == StIdle);
  assign out_if.valid = (st_q == StOut);
  assign out_if.digest_word = hash_word_i;
  assign out_if.word_index = idx_q;
  assign out_if.last_word = (idx_q == 3'd7);
  assign rd_idx_o = idx_q;

  always_comb begin
    st_d = st_q;
    idx_d = idx_q;
    extra_d = extra_q;
    launched_d = launched_q;
    cmd_o = '0;
    cmd_o.buf_src = SRC_DATA;
    unique case (st_q)
      StIdle: begin
        if (in_fire && in_if.kind == KindData) begin
          cmd_o.buf_we = 1'b1;
          if (sts_i.fill == 6'd63) begin
            cmd_o.fill_clr = 1'b1;
            launched_d = 1'b0;
            st_d = StWait;
          end
        end else if (in_fire) begin
          cmd_o.buf_we = 1'b1;
          cmd_o.buf_src = SRC_PAD;
          cmd_o.snap_len = 1'b1;
          extra_d = (sts_i.fill >= 6'd56);
          launched_d = 1'b0;
          // Pad byte in the last slot fills the block: compress it at once.
          if (sts_i.fill == 6'd63) begin
            cmd_o.fill_clr = 1'b1;
            st_d = StPadW;
          end else begin
            st_d = StPad;
          end
        end
      end
      StWait: begin
        // Buffer is written; launch rounds, then wait.
        if (!launched_q) begin
          cmd_o.cmp_start = 1'b1;
          cmd_o.len_add = 1'b1;
          launched_d = 1'b1;
        end else if (!sts_i.cmp_busy) begin
          st_d = StIdle;
        end
      end
      StPad: begin
        cmd_o.buf_we = 1'b1;
        if (extra_q) begin
          cmd_o.buf_src = SRC_ZERO;
          if (sts_i.fill == 6'd63) begin
            cmd_o.fill_clr = 1'b1;
            st_d = StPadW;
          end
        end else begin
          cmd_o.buf_src = (sts_i.fill >= 6'd56) ? SRC_LEN : SRC_ZERO;
          if (sts_i.fill == 6'd63) begin
            cmd_o.fill_clr = 1'b1;
            st_d = StFinW;
          end
        end
      end
      StPadW: begin
        if (!launched_q) begin
          cmd_o.cmp_start = 1'b1;
          launched_d = 1'b1;
        end else if (!sts_i.cmp_busy) begin
          extra_d = 1'b0;
          launched_d = 1'b0;
          st_d = StPad;
        end
      end
      StFinW: begin
        if (!launched_q) begin
          cmd_o.cmp_start = 1'b1;
          launched_d = 1'b1;
        end else if (!sts_i.cmp_busy) begin
          idx_d = '0;
          st_d = StOut;
        end
      end
      StOut: begin
        if (out_fire) begin
          idx_d = idx_q + 3'd1;
          if (idx_q == 3'd7) begin
            cmd_o.hash_init = 1'b1;
            st_d = StIdle;
          end
        end
      end
      default: st_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StIdle;
      idx_q <= '0;
      extra_q <= 1'b0;
      launched_q <= 1'b0;
    end else begin
      st_q <= st_d;
      idx_q <= idx_d;
      extra_q <= extra_d;
      launched_q <= launched_d;
    end
  end

  a_out_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_fire && idx_q != 3'd7) |=> (out_if.valid && idx_q == $past(idx_q) + 3'd1))
    else $error("digest words out of order");
  a_no_in_when_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_if.ready && out_if.valid)) else $error("input open during digest");
  a_last_init: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_fire && out_if.last_word) |=> st_q == StIdle)
    else $error("no return to idle after digest");
endmodule

@@ tb/sha_tb_checker.sv @@
// Digest checker for the SHA-256 byte-stream hasher: watches both channels,
// predicts each digest and compares it word by word. Depends on sha_pkg, sha_if.
`timescale 1ns / 1ps
module sha_tb_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  sha_in_if.sink      in_mon,
  sha_out_if.sink     out_mon,
  output int unsigned fail_count_o,
  output int unsigned pending_o
);
  import sha_pkg::*;

  typedef struct {
    logic [31:0] word;
    logic [2:0]  index;
    logic        last;
  } digest_beat_t;

  digest_beat_t digest_q[$];
  logic [7:0]   msg_buf [BlockBytes];
  logic [5:0]   msg_fill;
  logic [63:0]  msg_bits;
  logic [31:0]  chain [HashWords];

  localparam logic [31:0] RoundK [64] = '{
    32'h428a2f98,32'h71374491,32'hb5c0fbcf,32'he9b5dba5,32'h3956c25b,32'h59f111f1,
    32'h923f82a4,32'hab1c5ed5,32'hd807aa98,32'h12835b01,32'h243185be,32'h550c7dc3,
    32'h72be5d74,32'h80deb1fe,32'h9bdc06a7,32'hc19bf174,32'he49b69c1,32'hefbe4786,
    32'h0fc19dc6,32'h240ca1cc,32'h2de92c6f,32'h4a7484aa,32'h5cb0a9dc,32'h76f988da,
    32'h983e5152,32'ha831c66d,32'hb00327c8,32'hbf597fc7,32'hc6e00bf3,32'hd5a79147,
    32'h06ca6351,32'h14292967,32'h27b70a85,32'h2e1b2138,32'h4d2c6dfc,32'h53380d13,
    32'h650a7354,32'h766a0abb,32'h81c2c92e,32'h92722c85,32'ha2bfe8a1,32'ha81a664b,
    32'hc24b8b70,32'hc76c51a3,32'hd192e819,32'hd6990624,32'hf40e3585,32'h106aa070,
    32'h19a4c116,32'h1e376c08,32'h2748774c,32'h34b0bcb5,32'h391c0cb3,32'h4ed8aa4a,
    32'h5b9cca4f,32'h682e6ff3,32'h748f82ee,32'h78a5636f,32'h84c87814,32'h8cc70208,
    32'h90befffa,32'ha4506ceb,32'hbef9a3f7,32'hc67178f2
  };

  function automatic logic [31:0] rotr(logic [31:0] x, int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  task automatic compress_msg_block();
    logic [31:0] w [64];
    logic [31:0] v [8];
    logic [31:0] t1, t2, s0, s1;
    for (int i = 0; i < 16; i++)
      w[i] = {msg_buf[4*i], msg_buf[4*i+1], msg_buf[4*i+2], msg_buf[4*i+3]};
    for (int i = 16; i < 64; i++) begin
      s0 = rotr(w[i-15], 7) ^ rotr(w[i-15], 18) ^ (w[i-15] >> 3);
      s1 = rotr(w[i-2], 17) ^ rotr(w[i-2], 19) ^ (w[i-2] >> 10);
      w[i] = s1 + w[i-7] + s0 + w[i-16];
    end
    for (int i = 0; i < 8; i++) v[i] = chain[i];
    for (int i = 0; i < 64; i++) begin
      t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25))
         + ((v[4] & v[5]) ^ (~v[4] & v[6])) + RoundK[i] + w[i];
      t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22))
         + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
      v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) chain[i] = chain[i] + v[i];
  endtask

  task automatic restart_msg();
    msg_fill = '0;
    msg_bits = '0;
    for (int i = 0; i < 8; i++) chain[i] = IV[i];
  endtask

  task automatic absorb_beat(logic kind, logic [7:0] data);
    logic [63:0] total;
    int p;
    digest_beat_t b;
    if (kind == KindData) begin
      msg_buf[msg_fill] = data;
      if (msg_fill == 6'd63) begin
        compress_msg_block();
        msg_bits = msg_bits + BlockBits;
      end
      msg_fill = msg_fill + 6'd1;
    end else begin
      total = msg_bits + 64'(msg_fill) * 8;
      p = msg_fill;
      msg_buf[p++] = PadByte;
      if (msg_fill >= 56) begin
        while (p < 64) msg_buf[p++] = 8'h00;
        compress_msg_block();
        p = 0;
      end
      while (p < 56) msg_buf[p++] = 8'h00;
      for (int i = 0; i < 8; i++) msg_buf[63-i] = total[8*i +: 8];
      compress_msg_block();
      for (int i = 0; i < 8; i++) begin
        b.word = chain[i]; b.index = 3'(i); b.last = (i == 7);
        digest_q = {digest_q, b};
      end
      restart_msg();
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    digest_beat_t e;
    int unsigned errs;
    errs = 0;
    if (!rst_ni) begin
      restart_msg();
      digest_q.delete();
      pending_o = 0;
      fail_count_o <= 0;
    end else begin
      if (in_mon.valid && in_mon.ready) absorb_beat(in_mon.kind, in_mon.data_byte);
      if (out_mon.valid && out_mon.ready) begin
        if (digest_q.size() == 0) begin
          $error("unexpected digest beat %h", out_mon.digest_word);
          errs++;
        end else begin
          e = digest_q.pop_front();
          if (out_mon.digest_word !== e.word) begin
            $error("digest_word: exp %h got %h", e.word, out_mon.digest_word);
            errs++;
          end
          if (out_mon.word_index !== e.index) begin
            $error("word_index: exp %0d got %0d", e.index, out_mon.word_index);
            errs++;
          end
          if (out_mon.last_word !== e.last) begin
            $error("last_word: exp %0b got %0b", e.last, out_mon.last_word);
            errs++;
          end
        end
      end
      pending_o = digest_q.size();
      fail_count_o <= fail_count_o + errs;
    end
  end
endmodule

@@ tb/tb_top.sv @@
// Top of the SHA-256 hasher testbench: clock, reset, byte-stream stimulus,
// verdict. Depends on sha_pkg, sha_if, sha_tb_checker and the hasher RTL.
`timescale 1ns / 1ps
module tb_top;
  import sha_pkg::*;

  localparam int StallLimit = 20000;  // idle cycles before giving up

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  int unsigned fail_count, pending;
  int unsigned idle_cycles = 0;

  sha_in_if  in_if ();
  sha_out_if out_if ();

  sha256_byte_stream_hasher_top i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_if  (in_if.sink),
    .out_if (out_if.source)
  );

  sha_tb_checker i_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_mon       (in_if.sink),
    .out_mon      (out_if.sink),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always #2 clk_i = ~clk_i;

  // Gap length: mostly none or short, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 93) return $urandom_range(1, 4);
    return $urandom_range(10, 90);
  endfunction

  // Sink side: ready toggles with random gaps; calm stretches keep it high.
  initial begin
    int g;
    out_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      g = ($urandom_range(0, 9) < 3) ? 0 : pick_gap();
      out_if.ready <= (g == 0);
      repeat (g == 0 ? $urandom_range(1, 12) : g) @(posedge clk_i);
    end
  end

  // Drive one beat; valid stays high straight into the next beat when no gap.
  task automatic send_beat(logic kind, logic [7:0] data, bit gaps);
    int g;
    g = gaps ? pick_gap() : 0;
    if (g > 0) begin
      in_if.valid <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
    in_if.valid     <= 1'b1;
    in_if.kind      <= kind;
    in_if.data_byte <= data;
    do @(posedge clk_i); while (!in_if.ready);
  endtask

  task automatic send_message(int len, bit gaps, int pattern);
    logic [7:0] b;
    for (int i = 0; i < len; i++) begin
      case (pattern)
        0:       b = 8'h00;
        1:       b = 8'hff;
        default: b = 8'($urandom_range(0, 255));
      endcase
      send_beat(KindData, b, gaps);
    end
    send_beat(KindFinish, 8'($urandom_range(0, 255)), gaps);
  endtask

  // Watchdog: any cycle without an accepted beat on either side counts.
  always @(posedge clk_i) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= StallLimit) begin
      $display("tb_top: FAIL");
      $finish;
    end
  end

  initial begin
    int len;
    in_if.valid     = 1'b0;
    in_if.kind      = KindData;
    in_if.data_byte = 8'h00;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty message, one byte of each extreme, then a short and an empty message with gaps.
    send_message(0, 0, 2);
    send_message(1, 0, 0);
    send_message(1, 0, 1);
    send_message(3, 1, 2);
    send_message(0, 1, 2);

    // Hold off until the digest has drained, after letting the last beat land.
    in_if.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);

    // Padding boundaries: messages of 55, 56 and 64 bytes.
    send_message(55, 1, 2);
    send_message(56, 0, 2);
    send_message(64, 1, 1);

    // Random messages, mostly short, a few crossing one or two blocks.
    for (int m = 0; m < 9; m++) begin
      len = ($urandom_range(0, 9) < 7) ? $urandom_range(0, 12) : $urandom_range(50, 130);
      send_message(len, 1, 2);
      if (m == 4) begin
        in_if.valid <= 1'b0;
        @(posedge clk_i);
        while (pending != 0) @(posedge clk_i);
      end
    end
    in_if.valid <= 1'b0;

    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    if (fail_count == 0)
      $display("tb_top: PASS");
    else
      $display("tb_top: FAIL");
    $finish;
  end
endmodule
